@@ design/trfc_pkg.sv @@
package trfc_pkg;

  localparam int unsigned FrameBytes = 29;
  localparam int unsigned BodyBytes  = FrameBytes - 2;
  localparam int unsigned StoreBits  = BodyBytes * 8;
  localparam int unsigned CountBits  = 5;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [CountBits-1:0] CrcLowIdx = CountBits'(BodyBytes);
  localparam logic [CountBits-1:0] DoneIdx   = CountBits'(FrameBytes);

  typedef struct packed {
    logic [7:0]  device_id;
    logic [7:0]  command;
    logic [7:0]  length_byte;
    logic [15:0] data_kind;
    logic [15:0] tag_kind;
    logic [15:0] block_address;
    logic [15:0] payload_length;
    logic [63:0] ident_upper;
    logic [63:0] ident_lower;
  } result_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ design/trfc_collector.sv @@
module trfc_collector (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  output logic               res_valid_o,
  output trfc_pkg::result_t  res_o
);
  import trfc_pkg::*;

  logic [CountBits-1:0] count_q, count_d, count_eff;
  logic                 active_q, active_d, active_eff;
  logic [15:0]          crc_q, crc_d, crc_eff;
  logic [7:0]           crc_low_q, crc_low_d;
  logic [StoreBits-1:0] store_q, store_d;

  always_comb begin
    active_eff  = frame_start_i | active_q;
    count_eff   = frame_start_i ? '0 : count_q;
    crc_eff     = frame_start_i ? CrcInit : crc_q;
    count_d     = count_q;
    active_d    = active_q;
    crc_d       = crc_q;
    crc_low_d   = crc_low_q;
    store_d     = store_q;
    res_valid_o = 1'b0;
    if (accept_i && active_eff) begin
      active_d = 1'b1;
      count_d  = count_eff;
      crc_d    = crc_eff;
      if (count_eff < CrcLowIdx) begin
        store_d = {store_q[StoreBits-9:0], rx_byte_i};
        crc_d   = crc_byte(crc_eff, rx_byte_i);
        count_d = count_eff + 1'b1;
      end else if (count_eff == CrcLowIdx) begin
        crc_low_d = rx_byte_i;
        count_d   = count_eff + 1'b1;
      end else begin
        active_d    = 1'b0;
        count_d     = DoneIdx;
        res_valid_o = ({rx_byte_i, crc_low_q} == crc_eff);
      end
    end
  end

  // The oldest byte of the frame sits at the top of the store.
  assign res_o = result_t'(store_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      active_q  <= 1'b0;
      crc_q     <= CrcInit;
      crc_low_q <= '0;
    end else begin
      count_q   <= count_d;
      active_q  <= active_d;
      crc_q     <= crc_d;
      crc_low_q <= crc_low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

endmodule

@@ design/trfc_out_buf.sv @@
module trfc_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  trfc_pkg::result_t  res_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output trfc_pkg::result_t  out_o
);
  import trfc_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_free;

  always_comb begin
    out_free     = !out_valid_q || !out_stall_i;
    out_valid_d  = out_valid_q && out_stall_i;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_free) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (res_valid_i) begin
      if (out_free) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

@@ design/tag_reader_frame_checker_top.sv @@
// Checks fixed 29-byte tag reader frames, one received byte per request; a byte with
// frame_start high opens a frame and restarts any frame in progress. The Modbus CRC-16 over
// the first 27 bytes is updated a whole byte at a time in the collector, so the rate is one
// request and one byte per cycle unless in_stall_o is high. When the 29th byte arrives and
// the CRC matches, the decoded fields are registered in the output entry, or the skid entry
// if it is held; bad or cut-short frames give nothing. A two-entry output buffer lets bytes
// keep flowing while a result waits; the input stalls only when both entries are held.
module tag_reader_frame_checker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  device_id_o,
  output logic [7:0]  command_o,
  output logic [7:0]  length_byte_o,
  output logic [15:0] data_kind_o,
  output logic [15:0] tag_kind_o,
  output logic [15:0] block_address_o,
  output logic [15:0] payload_length_o,
  output logic [63:0] ident_upper_o,
  output logic [63:0] ident_lower_o
);
  import trfc_pkg::*;

  logic    accept;
  logic    res_valid;
  logic    full;
  result_t res;
  result_t out;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  trfc_collector u_collector (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  trfc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out)
  );

  assign device_id_o      = out.device_id;
  assign command_o        = out.command;
  assign length_byte_o    = out.length_byte;
  assign data_kind_o      = out.data_kind;
  assign tag_kind_o       = out.tag_kind;
  assign block_address_o  = out.block_address;
  assign payload_length_o = out.payload_length;
  assign ident_upper_o    = out.ident_upper;
  assign ident_lower_o    = out.ident_lower;

endmodule

@@ sim/tag_frame_scoreboard_pkg.sv @@
package tag_frame_scoreboard_pkg;

  import trfc_pkg::*;

  class tag_frame_scoreboard;
    logic [7:0]  body_bytes [BodyBytes];
    int unsigned byte_pos;
    bit          in_frame;
    logic [15:0] crc_run;
    logic [7:0]  crc_low;
    result_t     decoded_q [$];
    int unsigned bytes_taken;
    int unsigned bytes_ignored;
    int unsigned frames_good;
    int unsigned frames_rejected;
    int unsigned results_checked;
    int unsigned errors;

    function new();
      byte_pos        = 0;
      in_frame        = 1'b0;
      crc_run         = CrcInit;
      crc_low         = 8'h00;
      bytes_taken     = 0;
      bytes_ignored   = 0;
      frames_good     = 0;
      frames_rejected = 0;
      results_checked = 0;
      errors          = 0;
    endfunction

    // Bit-serial form of the reflected CRC-16: feedback is the low CRC bit
    // exclusive-ored with the next data bit, least significant first.
    static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c  = c >> 1;
        if (fb) c = c ^ CrcPoly;
      end
      return c;
    endfunction

    function void take_byte(logic [7:0] rx, logic start);
      result_t r;
      if (start) begin
        byte_pos = 0;
        crc_run  = CrcInit;
        in_frame = 1'b1;
      end
      if (!in_frame) begin
        bytes_ignored++;
        return;
      end
      bytes_taken++;
      if (byte_pos < BodyBytes) begin
        body_bytes[byte_pos] = rx;
        crc_run = crc_step(crc_run, rx);
        byte_pos++;
      end else if (byte_pos == BodyBytes) begin
        crc_low = rx;
        byte_pos++;
      end else begin
        in_frame = 1'b0;
        if ({rx, crc_low} != crc_run) begin
          frames_rejected++;
          return;
        end
        r.device_id      = body_bytes[0];
        r.command        = body_bytes[1];
        r.length_byte    = body_bytes[2];
        r.data_kind      = {body_bytes[3], body_bytes[4]};
        r.tag_kind       = {body_bytes[5], body_bytes[6]};
        r.block_address  = {body_bytes[7], body_bytes[8]};
        r.payload_length = {body_bytes[9], body_bytes[10]};
        r.ident_upper    = '0;
        r.ident_lower    = '0;
        for (int k = 0; k < 8; k++) begin
          r.ident_upper = {r.ident_upper[55:0], body_bytes[11 + k]};
          r.ident_lower = {r.ident_lower[55:0], body_bytes[19 + k]};
        end
        decoded_q.push_back(r);
        frames_good++;
      end
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s expected %0h got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_decoded(result_t got);
      result_t want;
      if (decoded_q.size() == 0) begin
        $error("Unexpected result, no good frame pending: device_id %0h", got.device_id);
        errors++;
        return;
      end
      want = decoded_q.pop_front();
      results_checked++;
      compare("device_id", want.device_id, got.device_id);
      compare("command", want.command, got.command);
      compare("length_byte", want.length_byte, got.length_byte);
      compare("data_kind", want.data_kind, got.data_kind);
      compare("tag_kind", want.tag_kind, got.tag_kind);
      compare("block_address", want.block_address, got.block_address);
      compare("payload_length", want.payload_length, got.payload_length);
      compare("ident_upper", want.ident_upper, got.ident_upper);
      compare("ident_lower", want.ident_lower, got.ident_lower);
    endfunction
  endclass

endpackage

@@ sim/tag_reader_frame_checker_top_tb.sv @@
module tag_reader_frame_checker_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import trfc_pkg::*;
  import tag_frame_scoreboard_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;

  typedef enum int unsigned {
    FillRandom,
    FillZero,
    FillOnes,
    FillAlt,
    FillEdge
  } fill_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte     = 8'h00;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [7:0]  device_id;
  logic [7:0]  command;
  logic [7:0]  length_byte;
  logic [15:0] data_kind;
  logic [15:0] tag_kind;
  logic [15:0] block_address;
  logic [15:0] payload_length;
  logic [63:0] ident_upper;
  logic [63:0] ident_lower;

  result_t     seen;
  logic [7:0]  frame_buf [FrameBytes];
  bit          send_gaps = 1'b1;
  bit          rx_gaps   = 1'b1;
  bit          long_hold = 1'b0;
  int unsigned cycles    = 0;

  tag_frame_scoreboard sb;

  tag_reader_frame_checker_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .rx_byte_i       (rx_byte),
    .frame_start_i   (frame_start),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .device_id_o     (device_id),
    .command_o       (command),
    .length_byte_o   (length_byte),
    .data_kind_o     (data_kind),
    .tag_kind_o      (tag_kind),
    .block_address_o (block_address),
    .payload_length_o(payload_length),
    .ident_upper_o   (ident_upper),
    .ident_lower_o   (ident_lower)
  );

  assign seen = {device_id, command, length_byte, data_kind, tag_kind, block_address,
                 payload_length, ident_upper, ident_lower};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tag_reader_frame_checker_top_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      sb.check_decoded(seen);
    end
  end

  // The long hold is counted here so that the sender keeps offering requests meanwhile.
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic build_frame(input int unsigned fill);
    logic [15:0] crc;
    crc = CrcInit;
    for (int k = 0; k < BodyBytes; k++) begin
      case (fill)
        FillZero: frame_buf[k] = 8'h00;
        FillOnes: frame_buf[k] = 8'hFF;
        FillAlt:  frame_buf[k] = k[0] ? 8'hAA : 8'h55;
        FillEdge: frame_buf[k] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        default:  frame_buf[k] = 8'($urandom);
      endcase
      crc = tag_frame_scoreboard::crc_step(crc, frame_buf[k]);
    end
    frame_buf[BodyBytes]     = crc[7:0];
    frame_buf[BodyBytes + 1] = crc[15:8];
  endtask

  task automatic send_byte(input logic [7:0] b, input logic start);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    frame_start <= start;
    do @(posedge clk_i); while (in_stall);
    sb.take_byte(b, start);
  endtask

  task automatic send_frame(input int unsigned n);
    for (int k = 0; k < n; k++) begin
      send_byte(frame_buf[k], k == 0);
    end
  endtask

  task automatic send_noise(input int unsigned n, input int unsigned start_odds);
    for (int k = 0; k < n; k++) begin
      send_byte(8'($urandom), (start_odds != 0) && ($urandom_range(0, start_odds - 1) == 0));
    end
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.decoded_q.size() != 0);
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned idx;
    bit          held;
    bit          paused;
    held   = 1'b0;
    paused = 1'b0;
    sb     = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: stray bytes with no open frame, extreme field values, CRC faults,
    // trailing bytes after a complete frame and frames cut short by a new start.
    send_noise(3, 0);
    build_frame(FillZero);
    send_frame(FrameBytes);
    build_frame(FillOnes);
    send_frame(FrameBytes);
    send_noise(4, 0);
    build_frame(FillAlt);
    send_frame(FrameBytes);
    build_frame(FillRandom);
    frame_buf[BodyBytes] ^= 8'h01;
    send_frame(FrameBytes);
    build_frame(FillRandom);
    frame_buf[BodyBytes + 1] ^= 8'h80;
    send_frame(FrameBytes);
    build_frame(FillRandom);
    frame_buf[0] ^= 8'h10;
    send_frame(FrameBytes);
    build_frame(FillRandom);
    send_frame(10);
    build_frame(FillRandom);
    send_frame(BodyBytes + 1);
    build_frame(FillOnes);
    send_frame(FrameBytes);
    build_frame(FillRandom);
    send_frame(BodyBytes);
    build_frame(FillRandom);
    send_frame(FrameBytes);

    while (sb.bytes_taken < 1350) begin
      if (sb.bytes_taken > 1150) begin
        send_gaps = 1'b0;
        rx_gaps   = 1'b0;
      end else begin
        send_gaps = ($urandom_range(0, 4) != 0);
        rx_gaps   = ($urandom_range(0, 4) != 0);
      end
      if (!held && sb.bytes_taken > 500) begin
        held      = 1'b1;
        send_gaps = 1'b0;
        long_hold = 1'b1;
        repeat (4) begin
          build_frame(FillRandom);
          send_frame(FrameBytes);
        end
      end else if (!paused && sb.bytes_taken > 850) begin
        paused = 1'b1;
        wait_results();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          build_frame(($urandom_range(0, 7) == 0) ? FillEdge : FillRandom);
          send_frame(FrameBytes);
        end else if (pick < 77) begin
          build_frame(FillRandom);
          idx = $urandom_range(0, FrameBytes - 1);
          frame_buf[idx] ^= 8'(1 << $urandom_range(0, 7));
          send_frame(FrameBytes);
        end else if (pick < 90) begin
          build_frame(FillRandom);
          send_frame($urandom_range(1, FrameBytes - 1));
        end else begin
          send_noise($urandom_range(1, 4), 8);
        end
      end
    end

    wait_results();
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d frame bytes and %0d stray bytes: %0d good frames, %0d CRC rejects.",
             sb.bytes_taken, sb.bytes_ignored, sb.frames_good, sb.frames_rejected);
    $display("Decoded results checked: %0d, with output back-pressure and input gaps.",
             sb.results_checked);
    if (sb.errors == 0) begin
      $display("tag_reader_frame_checker_top_tb OK");
    end else begin
      $display("tag_reader_frame_checker_top_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/trfc_pkg.sv
design/trfc_collector.sv
design/trfc_out_buf.sv
design/tag_reader_frame_checker_top.sv
sim/tag_frame_scoreboard_pkg.sv
sim/tag_reader_frame_checker_top_tb.sv
